// ===== sv/rgb_level_dimmer_unit_assert.svh =====
// Assertion macros for the RGB level dimmer.
// Used by rgb_level_dimmer_unit; expects clk and rst in scope.
`ifndef RGB_LEVEL_DIMMER_UNIT_ASSERT_SVH
`define RGB_LEVEL_DIMMER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define RLD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rld: check failed");

// Check that a condition holds in the cycle after a trigger.
`define RLD_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("rld: check failed one cycle after trigger");

`endif

// ===== sv/rld_pkg.sv =====
// Shared types and constants for the RGB level dimmer.
// No dependencies; imported by rgb_level_dimmer_unit.
package rld_pkg;

  localparam int unsigned NUM_CH = 3;

  localparam logic [7:0]  LEVEL_MAX   = 8'd255;
  localparam logic [14:0] BRIGHT_FULL = 15'd25600;  // 100 percent in Q7.8
  // floor(x / 100) == (x * 5243) >> 19 for every x up to 25500
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_UP      = 3'd1,
    OP_DOWN    = 3'd2,
    OP_BR_UP   = 3'd3,
    OP_BR_DOWN = 3'd4,
    OP_FLUCT   = 3'd5,
    OP_RESET   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef logic [7:0] level_t;

endpackage

// ===== sv/rgb_level_dimmer_unit.sv =====
// RGB level dimmer: top level with command decode, state and output scaling.
// Depends on rld_pkg and rgb_level_dimmer_unit_assert.svh.
`include "rgb_level_dimmer_unit_assert.svh"

// Takes one command word per cycle while s_axis_tready is high and returns
// one result word per command, in order. It sustains one word per clock
// while m_axis_tready is high: a command updates the three colour levels,
// the ramp flags and the brightness as it leaves the command register, so
// the next command already sees the new state. The result shows the levels
// after the command and each level scaled by brightness (floor(level *
// brightness / 25600)), computed in two registered multiply steps: level
// times brightness, then a reciprocal multiply for the divide by 100. Each
// stage holds its word until the next can take it, so s_axis_tready drops
// only when all four stages carry words. Reset leaves the levels at zero,
// all channels rising and brightness at 100 percent.
module rgb_level_dimmer_unit
  import rld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] op, [4:3] channel, [12:5] amount, [27:13] brightness_step
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] drive_red, [15:8] drive_green, [23:16] drive_blue,
  // [31:24] level_red, [39:32] level_green, [47:40] level_blue
  output logic [47:0] m_axis_tdata,
  // [0] refresh
  output logic        m_axis_tuser
);

  // Pipeline valids and per-stage ready (stage may load when empty or draining)
  logic cmd_valid, mix_valid, prod_valid, out_valid;
  logic cmd_rdy, mix_rdy, prod_rdy, out_rdy;

  assign out_rdy  = !out_valid  || m_axis_tready;
  assign prod_rdy = !prod_valid || out_rdy;
  assign mix_rdy  = !mix_valid  || prod_rdy;
  assign cmd_rdy  = !cmd_valid  || mix_rdy;

  assign s_axis_tready = cmd_rdy;

  logic in_take, cmd_take;
  assign in_take  = s_axis_tvalid && cmd_rdy;
  assign cmd_take = cmd_valid && mix_rdy;

  // Command register
  op_t         cmd_op;
  logic [1:0]  cmd_ch;
  logic [7:0]  cmd_amount;
  logic [14:0] cmd_bstep;

  // Block state
  level_t      levels [NUM_CH];
  logic [NUM_CH-1:0] rising;
  logic [14:0] brightness;

  level_t      levels_next [NUM_CH];
  logic [NUM_CH-1:0] rising_next;
  logic [14:0] brightness_next;
  logic        refresh_next;

  // Snapshot of state after a command
  level_t      mix_levels [NUM_CH];
  logic [14:0] mix_bright;
  logic        mix_refresh;

  // Level times brightness, divided by 256
  logic [14:0] prod_scaled [NUM_CH];
  level_t      prod_levels [NUM_CH];
  logic        prod_refresh;

  // Result register
  level_t      drive   [NUM_CH];
  level_t      out_lvl [NUM_CH];
  logic        out_refresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_rdy) begin
      cmd_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_op     <= op_t'(s_axis_tdata[2:0]);
      cmd_ch     <= s_axis_tdata[4:3];
      cmd_amount <= s_axis_tdata[12:5];
      cmd_bstep  <= s_axis_tdata[27:13];
    end
  end

  // Command decode: saturating level steps, clamped brightness, triangle ramp
  always_comb begin
    logic [8:0]  lsum;
    logic [15:0] bsum;
    for (int i = 0; i < NUM_CH; i++) begin
      levels_next[i] = levels[i];
    end
    rising_next     = rising;
    brightness_next = brightness;
    refresh_next    = 1'b0;
    lsum            = '0;
    bsum            = '0;
    case (cmd_op)
      OP_SET: begin
        if (cmd_ch < 2'(NUM_CH)) begin
          levels_next[cmd_ch] = cmd_amount;
        end
      end
      OP_UP: begin
        if (cmd_ch < 2'(NUM_CH)) begin
          lsum = {1'b0, levels[cmd_ch]} + {1'b0, cmd_amount};
          levels_next[cmd_ch] = lsum[8] ? LEVEL_MAX : lsum[7:0];
        end
        refresh_next = 1'b1;
      end
      OP_DOWN: begin
        if (cmd_ch < 2'(NUM_CH)) begin
          levels_next[cmd_ch] = (levels[cmd_ch] > cmd_amount) ?
                                (levels[cmd_ch] - cmd_amount) : 8'd0;
        end
        refresh_next = 1'b1;
      end
      OP_BR_UP: begin
        bsum = {1'b0, brightness} + {1'b0, cmd_bstep};
        brightness_next = (bsum >= {1'b0, BRIGHT_FULL}) ? BRIGHT_FULL : bsum[14:0];
        refresh_next = 1'b1;
      end
      OP_BR_DOWN: begin
        brightness_next = (brightness > cmd_bstep) ? (brightness - cmd_bstep) : 15'd0;
        refresh_next = 1'b1;
      end
      OP_FLUCT: begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (rising[i]) begin
            lsum = {1'b0, levels[i]} + {1'b0, cmd_amount};
            if (lsum >= {1'b0, LEVEL_MAX}) begin
              levels_next[i] = LEVEL_MAX;
              rising_next[i] = 1'b0;
            end else begin
              levels_next[i] = lsum[7:0];
            end
          end else if (levels[i] <= cmd_amount) begin
            levels_next[i] = 8'd0;
            rising_next[i] = 1'b1;
          end else begin
            levels_next[i] = levels[i] - cmd_amount;
          end
        end
        refresh_next = 1'b1;
      end
      OP_RESET: begin
        for (int i = 0; i < NUM_CH; i++) begin
          levels_next[i] = 8'd0;
        end
        rising_next  = '1;
        refresh_next = 1'b1;
      end
      default: begin
        refresh_next = 1'b0;
      end
    endcase
  end

  // Commit state as the command moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        levels[i] <= 8'd0;
      end
      rising     <= '1;
      brightness <= BRIGHT_FULL;
    end else if (cmd_take) begin
      levels     <= levels_next;
      rising     <= rising_next;
      brightness <= brightness_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (mix_rdy) begin
      mix_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      mix_levels  <= levels_next;
      mix_bright  <= brightness_next;
      mix_refresh <= refresh_next;
    end
  end

  // Scale step one: level * brightness, drop the Q7.8 fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_rdy) begin
      prod_valid <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [22:0] prod;
    if (mix_valid && prod_rdy) begin
      for (int i = 0; i < NUM_CH; i++) begin
        prod           = mix_levels[i] * mix_bright;
        prod_scaled[i] <= prod[22:8];
        prod_levels[i] <= mix_levels[i];
      end
      prod_refresh <= mix_refresh;
    end
  end

  // Scale step two: divide by 100 through the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_rdy) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [27:0] quot;
    if (prod_valid && out_rdy) begin
      for (int i = 0; i < NUM_CH; i++) begin
        quot       = prod_scaled[i] * RECIP_100;
        drive[i]   <= quot[RECIP_SHIFT+7:RECIP_SHIFT];
        out_lvl[i] <= prod_levels[i];
      end
      out_refresh <= prod_refresh;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_lvl[2], out_lvl[1], out_lvl[0], drive[2], drive[1], drive[0]};
  assign m_axis_tuser  = out_refresh;

  // Brightness never leaves its 0..100 percent range
  `RLD_ASSERT_ALWAYS(a_bright_range, brightness <= BRIGHT_FULL)

  // Scaling by at most full brightness never raises a level
  `RLD_ASSERT_ALWAYS(a_drive_le_level, !out_valid ||
    (drive[0] <= out_lvl[0] && drive[1] <= out_lvl[1] && drive[2] <= out_lvl[2]))

  // A colour reset clears all levels and sets all channels rising
  `RLD_ASSERT_NEXT(a_reset_clears, cmd_take && cmd_op == OP_RESET,
    levels[0] == 8'd0 && levels[1] == 8'd0 && levels[2] == 8'd0 && rising == '1)

endmodule
